// ===== hdl/fcsma_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsma_pkg
// Shared types, constants and helpers of the four channel scan moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsma_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned MUX_W      = 3;
  localparam int unsigned WINDOW_DEF = 8;
  localparam int unsigned IN_TDATA_W = 16;
  // four means, flags, mux code, start bit
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 12'd2048;

  // channel turn order, also the index of each limit register
  typedef enum logic [CH_W-1:0] {
    CH_LS = 2'd0,
    CH_LF = 2'd1,
    CH_RS = 2'd2,
    CH_RF = 2'd3
  } ch_e;

  localparam logic [MUX_W-1:0] DET_LS = 3'd6;
  localparam logic [MUX_W-1:0] DET_LF = 3'd7;
  localparam logic [MUX_W-1:0] DET_RS = 3'd5;
  localparam logic [MUX_W-1:0] DET_RF = 3'd4;

  function automatic logic [MUX_W-1:0] mux_code(input logic [CH_W-1:0] ch);
    logic [MUX_W-1:0] code;
    unique case (ch)
      CH_LS:   code = DET_LS;
      CH_LF:   code = DET_LF;
      CH_RS:   code = DET_RS;
      default: code = DET_RF;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fcsma_front.sv =====
// ----------------------------------------------------------------------------
// fcsma_front
// Accepts samples and tags each with its channel and ring slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsma_front
  import fcsma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  parameter int unsigned SLOT_W = 3,
  parameter int unsigned ITEM_W = SLOT_W + CH_W + SAMPLE_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,   // [11:0] sample
  output logic                       push_o,
  output logic      [ITEM_W-1:0]     item_o,
  input  wire logic                  queue_ready_i
);

  logic [CH_W-1:0]   ch_q, ch_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  assign s_axis_tready = queue_ready_i;
  assign push_o        = s_axis_tvalid && queue_ready_i;
  assign item_o        = {slot_q, ch_q, s_axis_tdata[SAMPLE_W-1:0]};

  always_comb begin
    ch_d   = ch_q;
    slot_d = slot_q;
    if (push_o) begin
      ch_d = ch_q + CH_W'(1);
      // slot moves on once the last channel of the scan is in
      if (ch_q == CH_RF) begin
        slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q   <= CH_LS;
      slot_q <= '0;
    end else begin
      ch_q   <= ch_d;
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fcsma_queue.sv =====
// ----------------------------------------------------------------------------
// fcsma_queue
// Four entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsma_queue
  import fcsma_pkg::*;
#(
  parameter int unsigned ITEM_W = 17
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [ITEM_W-1:0] item_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output logic      [ITEM_W-1:0] item_o,
  input  wire logic              pop_i
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = 2;

  logic [ITEM_W-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]    count_q;

  assign ready_o = (count_q != (PTR_W+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fcsma_back.sv =====
// ----------------------------------------------------------------------------
// fcsma_back
// Sample rings, running sums, window means, limit compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsma_back
  import fcsma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  parameter int unsigned SLOT_W = 3,
  parameter int unsigned ITEM_W = SLOT_W + CH_W + SAMPLE_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CH_W-1:0]        cfg_idx_i,
  input  wire logic [SAMPLE_W-1:0]    cfg_data_i,
  input  wire logic                   queue_valid_i,
  input  wire logic [ITEM_W-1:0]      queue_item_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned LOG_W   = $clog2(WINDOW);
  localparam int unsigned SUM_W   = SAMPLE_W + LOG_W;
  localparam int unsigned SHIFT   = SUM_W + LOG_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned ADDR_W  = SLOT_W + CH_W;
  localparam int unsigned DEPTH   = NUM_CH * WINDOW;
  // exact floor division by WINDOW for any sum below 2**SUM_W
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);
  localparam logic [SUM_W-1:0]   SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_W) - 1));

  logic                adv;
  logic [ADDR_W-1:0]   q_addr;

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]    written_q;
  logic [SAMPLE_W-1:0] limit_q [NUM_CH];
  logic [SUM_W-1:0]    sum_q [NUM_CH];
  logic [SUM_W-1:0]    sum_d [NUM_CH];

  // stage 1: item plus old sample read from the ring
  logic                s1_vld_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [ADDR_W-1:0]   s1_addr_q;
  logic [SAMPLE_W-1:0] s1_rd_q;
  logic                s1_rd_ok_q;
  logic [CH_W-1:0]     s1_ch;
  logic [SAMPLE_W-1:0] s1_old;
  logic [SUM_W-1:0]    s1_sum_new;

  // stage 2: sums snapshot, stage 3: reciprocal products
  logic                s2_vld_q;
  logic [CH_W-1:0]     s2_ch_q;
  logic [SUM_W-1:0]    s2_sum_q [NUM_CH];
  logic                s3_vld_q;
  logic [CH_W-1:0]     s3_ch_q;
  logic [PROD_W-1:0]   s3_prod_q [NUM_CH];

  logic [SAMPLE_W-1:0] mean [NUM_CH];
  logic [NUM_CH-1:0]   flags;
  logic [CH_W-1:0]     next_ch;

  logic                out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign adv    = !out_vld_q || m_axis_tready;
  assign pop_o  = adv && queue_valid_i;
  assign q_addr = queue_item_i[ITEM_W-1 -: ADDR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        limit_q[i] <= LIMIT_RESET;
      end
    end else if (cfg_we_i) begin
      limit_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // ring storage, read and written in clocked blocks
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_rd_q     <= mem_q[q_addr];
      s1_sample_q <= queue_item_i[SAMPLE_W-1:0];
      s1_addr_q   <= q_addr;
    end
    if (adv && s1_vld_q) begin
      mem_q[s1_addr_q] <= s1_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      s1_rd_ok_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_rd_ok_q <= written_q[q_addr];
      end
      if (adv && s1_vld_q) begin
        written_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  assign s1_ch      = s1_addr_q[CH_W-1:0];
  assign s1_old     = s1_rd_ok_q ? s1_rd_q : '0;
  assign s1_sum_new = sum_q[s1_ch] - SUM_W'(s1_old) + SUM_W'(s1_sample_q);

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum_d[i] = (s1_vld_q && (s1_ch == CH_W'(i))) ? s1_sum_new : sum_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sum_q[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ch_q <= s1_ch;
      s3_ch_q <= s2_ch_q;
      for (int i = 0; i < NUM_CH; i++) begin
        s2_sum_q[i]  <= sum_d[i];
        s3_prod_q[i] <= PROD_W'(s2_sum_q[i]) * PROD_W'(RECIP);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      mean[i]  = s3_prod_q[i][SHIFT +: SAMPLE_W];
      flags[i] = (mean[i] > limit_q[i]);
    end
  end

  assign next_ch = s3_ch_q + CH_W'(1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {next_ch != CH_LS, mux_code(next_ch), flags,
                     mean[CH_RF], mean[CH_RS], mean[CH_LF], mean[CH_LS]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= queue_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // consecutive items in the pipe come from consecutive channels
  a_channel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s2_vld_q) |-> (s1_ch == s2_ch_q + CH_W'(1)))
    else $error("channel order broken between stage 1 and 2");

  // ring write never hits the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_vld_q && queue_valid_i) |-> (q_addr != s1_addr_q))
    else $error("ring read and write collide");

  // running sum stays within a full window of maximum samples
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (s1_sum_new <= SUM_MAX))
    else $error("running sum out of range");

  // a result only appears behind an item that went through stage 3
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s3_vld_q))
    else $error("result without a source item");
`endif

endmodule

`default_nettype wire

// ===== hdl/four_channel_scan_moving_average.sv =====
// ----------------------------------------------------------------------------
// four_channel_scan_moving_average
// Running window means of a four detector round-robin scan with wall flags.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one 12-bit conversion result per transfer, in scan order
//   left side, left front, right side, right front, starting at left side.
//   m_axis returns one result per input transfer: the four window means,
//   the near flags, the mux code of the next detector and the start bit.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the four near limits (index 0 to 3);
//   write them only while no item is in flight.
// pipeline: an input transfer passes queue, ring read, sum update, reciprocal
//   multiply and compare; one item per cycle sustained while the output side
//   is ready, set by the single ring port pair.
// reset: sums, ring contents (through written bits), scan position and limits
//   return to their initial values at once; no clearing pass.
// stall: when m_axis_tready is low the back pipeline holds, the four entry
//   queue fills and then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_scan_moving_average
  import fcsma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CH_W-1:0]        cfg_idx_i,
  input  wire logic [SAMPLE_W-1:0]    cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] sample
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [11:0] mean_left_side, [23:12] mean_left_front, [35:24] mean_right_side,
  // [47:36] mean_right_front, [51:48] near_flags, [54:52] next_mux_code,
  // [55] start_now
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned ITEM_W = SLOT_W + CH_W + SAMPLE_W;

  logic              push;
  logic [ITEM_W-1:0] front_item;
  logic              queue_ready;
  logic              queue_valid;
  logic [ITEM_W-1:0] queue_item;
  logic              pop;

  fcsma_front #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W),
    .ITEM_W (ITEM_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .item_o        (front_item),
    .queue_ready_i (queue_ready)
  );

  fcsma_queue #(
    .ITEM_W (ITEM_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (queue_ready),
    .valid_o (queue_valid),
    .item_o  (queue_item),
    .pop_i   (pop)
  );

  fcsma_back #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W),
    .ITEM_W (ITEM_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .queue_valid_i (queue_valid),
    .queue_item_i  (queue_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four channel scan moving average. Samples go in
// on s_axis under random sender gaps; every m_axis transfer is checked field
// by field against a running-sum scan model kept here, across several sets of
// near limits, with random receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench;
  import fcsma_pkg::*;

  localparam int unsigned PHASE_ITEMS  = 400;
  localparam int unsigned DRAIN_SLACK  = 10;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

  localparam logic [MUX_W-1:0] DET_OF_CH [NUM_CH] = '{DET_LS, DET_LF, DET_RS, DET_RF};

  // msb first, so means[0] (left side) lands in tdata[11:0]
  typedef struct packed {
    logic                              start_now;
    logic [MUX_W-1:0]                  next_mux_code;
    logic [NUM_CH-1:0]                 near_flags;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]   means;
  } scan_result_t;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] limit_set_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CH_W-1:0]        cfg_idx_i = '0;
  logic [SAMPLE_W-1:0]    cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [11:0] sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [11:0] mean_left_side, [23:12] mean_left_front, [35:24] mean_right_side,
  // [47:36] mean_right_front, [51:48] near_flags, [54:52] next_mux_code,
  // [55] start_now
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // scan model state
  logic [SAMPLE_W-1:0] ring [NUM_CH][WINDOW_DEF] = '{default: '{default: '0}};
  int unsigned         win_sum [NUM_CH] = '{default: 0};
  logic [SAMPLE_W-1:0] near_limit [NUM_CH] = '{default: LIMIT_RESET};
  ch_e                 model_ch = CH_LS;
  int unsigned         scan_slot = 0;

  scan_result_t        awaited_scans [$];
  logic [SAMPLE_W-1:0] wall_level [NUM_CH] = '{default: '0};

  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  bit          hold_off_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  four_channel_scan_moving_average #(
    .WINDOW(WINDOW_DEF)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // store the sample, update the running sum, step the scan position
  function automatic scan_result_t predict_scan(input logic [IN_TDATA_W-1:0] word);
    scan_result_t        r;
    logic [SAMPLE_W-1:0] s;
    int unsigned         ch;
    s  = word[SAMPLE_W-1:0];
    ch = model_ch;
    win_sum[ch] = win_sum[ch] - ring[ch][scan_slot] + s;
    ring[ch][scan_slot] = s;
    ch = (ch + 1) % NUM_CH;
    model_ch = ch_e'(ch);
    if (model_ch == CH_LS) begin
      scan_slot = (scan_slot + 1) % WINDOW_DEF;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      r.means[i]      = SAMPLE_W'(win_sum[i] / WINDOW_DEF);
      r.near_flags[i] = r.means[i] > near_limit[i];
    end
    r.next_mux_code = DET_OF_CH[ch];
    r.start_now     = model_ch != CH_LS;
    return r;
  endfunction

  // each channel drifts around a wall distance that jumps now and then,
  // often parked at zero or full scale so the means reach the extremes
  function automatic logic [IN_TDATA_W-1:0] pick_word();
    logic [SAMPLE_W-1:0] v;
    int                  n;
    int unsigned         ch;
    ch = model_ch;
    if ($urandom_range(47) == 0) begin
      case ($urandom_range(3))
        0:       wall_level[ch] = '0;
        1:       wall_level[ch] = FULL_SCALE;
        default: wall_level[ch] = SAMPLE_W'($urandom_range(4095));
      endcase
    end
    if ($urandom_range(15) == 0) begin
      v = SAMPLE_W'($urandom_range(4095));
    end else if ((wall_level[ch] == '0 || wall_level[ch] == FULL_SCALE) &&
                 $urandom_range(3) != 0) begin
      v = wall_level[ch];
    end else begin
      n = int'(wall_level[ch]) + int'($urandom_range(128)) - 64;
      if (n < 0) n = 0;
      if (n > 4095) n = 4095;
      v = SAMPLE_W'(n);
    end
    // upper tdata bits are don't care and get random values
    return {4'($urandom_range(15)), v};
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic check_scan(input logic [OUT_TDATA_W-1:0] data);
    scan_result_t got;
    scan_result_t want;
    got = data;
    if (awaited_scans.size() == 0) begin
      flag_mismatch("result with none awaited, low word", data[31:0], 0);
    end else begin
      want = awaited_scans.pop_front();
      for (int i = 0; i < NUM_CH; i++) begin
        if (got.means[i] !== want.means[i]) begin
          flag_mismatch($sformatf("mean of channel %0d", i), got.means[i], want.means[i]);
        end
      end
      if (got.near_flags !== want.near_flags) begin
        flag_mismatch("near_flags", got.near_flags, want.near_flags);
      end
      if (got.next_mux_code !== want.next_mux_code) begin
        flag_mismatch("next_mux_code", got.next_mux_code, want.next_mux_code);
      end
      if (got.start_now !== want.start_now) begin
        flag_mismatch("start_now", got.start_now, want.start_now);
      end
    end
  endtask

  // receiver: check each transfer, then pick tready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_scan(m_axis_tdata);
    end
    if (hold_off_start) begin
      hold_left = HOLD_CYCLES;
      hold_off_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= dst_idle_pct;
    end
  end

  // valid stays high between back-to-back transfers
  task automatic send_sample(input logic [IN_TDATA_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_scans.push_back(predict_scan(word));
  endtask

  task automatic wait_scans_done();
    s_axis_tvalid <= 1'b0;
    while (awaited_scans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  // block must be idle here
  task automatic write_limits(input limit_set_t limits);
    ch_e c;
    c = c.first();
    repeat (NUM_CH) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= c;
      cfg_data_i <= limits[c];
      @(posedge clk_i);
      near_limit[c] = limits[c];
      c = c.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  // zeros in the first slot, then full scale until the means cross the
  // reset limit of 2048 (2047 stays clear, 2559 flags)
  task automatic test_fill_from_reset();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    for (int i = 0; i < 24; i++) begin
      if (i < NUM_CH) begin
        send_sample(16'hF000);
      end else begin
        send_sample((i % 2) ? 16'hFFFF : 16'h0FFF);
      end
    end
    wait_scans_done();
  endtask

  // limits equal to the current means must not flag, one below must
  task automatic test_limit_boundary();
    limit_set_t lim;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < NUM_CH; i++) begin
        lim[i] = SAMPLE_W'(win_sum[i] / WINDOW_DEF);
        if (k == 1 && lim[i] != '0) lim[i] = lim[i] - 1'b1;
      end
      write_limits(lim);
      repeat (6) send_sample(pick_word());
      wait_scans_done();
    end
  endtask

  task automatic test_random_scan(input int unsigned src_pct, input int unsigned dst_pct,
                                  input limit_set_t lim);
    write_limits(lim);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    for (int i = 0; i < NUM_CH; i++) wall_level[i] = SAMPLE_W'($urandom_range(4095));
    repeat (PHASE_ITEMS) send_sample(pick_word());
    wait_scans_done();
  endtask

  // long receiver hold-off fills the queue, then a full drain mid-stream
  task automatic test_backpressure();
    limit_set_t lim;
    for (int i = 0; i < NUM_CH; i++) lim[i] = SAMPLE_W'($urandom_range(1024, 3072));
    write_limits(lim);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_off_start = 1'b1;
    repeat (50) send_sample(pick_word());
    wait_scans_done();
    dst_idle_pct = 30;
    repeat (20) send_sample(pick_word());
    wait_scans_done();
  endtask

  initial begin
    limit_set_t lim;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_from_reset();
    test_limit_boundary();
    for (int i = 0; i < NUM_CH; i++) lim[i] = SAMPLE_W'($urandom_range(4095));
    test_random_scan(23, 59, lim);
    test_random_scan(59, 23, '0);
    test_random_scan(0, 0, '1);
    test_backpressure();

    if (mismatch_count == 0 && awaited_scans.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fcsma_pkg.sv
hdl/fcsma_front.sv
hdl/fcsma_queue.sv
hdl/fcsma_back.sv
hdl/four_channel_scan_moving_average.sv
tb/testbench.sv
